// ===== hw/rtl/limit_order_book_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the limit order book matcher
// Concurrent checks, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LOBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LOBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Beat types, result kinds, sequencer states and book entry types.
// ----------------------------------------------------------------------------
package lobm_pkg;

    typedef enum logic [1:0] {
        KIND_TRADE   = 2'd0,
        KIND_RESTED  = 2'd1,
        KIND_FILLED  = 2'd2,
        KIND_DROPPED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MATCH,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic        side;
        logic [31:0] order_id;
        logic [31:0] limit_price;
        logic [30:0] quantity;
    } order_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] trade_number;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [31:0] trade_price;
        logic [30:0] trade_qty;
        logic [30:0] left_qty;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [30:0] left;
    } entry_t;

    typedef struct packed {
        logic   remove;
        logic   set_left;
        logic   append;
        entry_t data;
    } book_cmd_t;

    typedef struct packed {
        logic take_next;
        logic load_new;
        logic set_left;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority matching of limit orders against two bounded books.
// ----------------------------------------------------------------------------
// Each order beat is matched against the opposite book, best price first and
// oldest first at one price. One order is worked at a time. The order is taken
// in the idle state. Every attempt to fill scans the opposite book, one cell
// per cycle, then moves to the match state. An empty opposite book ends the
// scan with no match. The final beat is sent from the final state. An order
// that stops on a price that no longer crosses pays one more scan and match.
// A trade or final beat waits while the output register holds a result that
// result_ready has not taken. The scan walks the chain of cells from the
// oldest slot up, so ties keep the older entry. Results leave through a
// one-beat output register; a new order is taken as soon as the sequencer is
// idle, even if the last result has not yet been taken. Books are empty after
// reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              order_valid,
    output logic              order_ready,
    input  lobm_pkg::order_t  order,
    output logic              result_valid,
    input  logic              result_ready,
    output lobm_pkg::result_t result
);
    import lobm_pkg::*;
    `include "limit_order_book_matcher_assert.svh"

    localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

    // Sequencer and working registers
    state_t      state_reg, state_next;
    order_t      order_reg;
    logic [30:0] want_reg;
    logic [IW-1:0] scan_idx_reg;
    logic [IW-1:0] best_idx_reg;
    logic [31:0] best_price_reg;
    logic [31:0] trade_reg;
    result_t     result_reg;
    logic        result_valid_reg;

    // Books
    book_cmd_t       bid_cmd, ask_cmd, opp_cmd, own_cmd;
    entry_t          bid_rd, ask_rd, opp_rd;
    logic [BOOK_DEPTH-1:0] bid_valid, ask_valid, opp_valid, own_valid, opp_up;
    logic [IW-1:0]   rd_slot;

    // Control
    logic        accept;
    logic        out_free;
    logic        sell;
    logic        better;
    logic        scan_done;
    logic        crosses;
    logic [30:0] fill_qty;
    logic [30:0] want_after;
    logic [30:0] rest_after;
    logic        entry_gone;
    logic        emit_trade;
    logic        emit_final;
    logic        do_append;
    kind_t       final_kind;

    assign sell      = order_reg.side;
    assign accept    = order_valid && order_ready;
    assign out_free  = !result_valid_reg || result_ready;
    assign opp_valid = sell ? bid_valid : ask_valid;
    assign own_valid = sell ? ask_valid : bid_valid;
    assign opp_rd    = sell ? bid_rd : ask_rd;
    assign opp_up    = opp_valid >> 1;
    assign rd_slot   = (state_reg == ST_MATCH) ? best_idx_reg : scan_idx_reg;

    // Scan: keep the strictly better price, so the oldest wins a tie
    assign better    = (scan_idx_reg == '0) ||
                       (sell ? (opp_rd.price > best_price_reg)
                             : (opp_rd.price < best_price_reg));
    assign scan_done = !opp_up[scan_idx_reg];

    // Match against the chosen entry
    assign crosses    = sell ? (order_reg.limit_price <= opp_rd.price)
                             : (order_reg.limit_price >= opp_rd.price);
    assign fill_qty   = (want_reg < opp_rd.left) ? want_reg : opp_rd.left;
    assign want_after = want_reg - fill_qty;
    assign rest_after = opp_rd.left - fill_qty;
    assign entry_gone = (rest_after == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (order.quantity == '0) ? ST_FINAL : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!opp_valid[0])
                begin
                    state_next = ST_FINAL;
                end
                else if (scan_done)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (!crosses)
                begin
                    state_next = ST_FINAL;
                end
                else if (out_free)
                begin
                    state_next = (entry_gone && want_after != '0) ? ST_SCAN : ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        order_ready = 1'b0;
        emit_trade  = 1'b0;
        emit_final  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  order_ready = 1'b1;
            ST_SCAN:  ;
            ST_MATCH: emit_trade  = crosses && out_free;
            ST_FINAL: emit_final  = out_free;
            default:  ;
        endcase
    end

    // Final outcome: filled, rested, or dropped on a full own book
    always_comb
    begin
        do_append = 1'b0;
        if (want_reg == '0)
        begin
            final_kind = KIND_FILLED;
        end
        else if (!own_valid[BOOK_DEPTH-1])
        begin
            final_kind = KIND_RESTED;
            do_append  = emit_final;
        end
        else
        begin
            final_kind = KIND_DROPPED;
        end
    end

    // Book commands: fills hit the opposite book, the remainder rests on its own
    always_comb
    begin
        opp_cmd           = '0;
        opp_cmd.remove    = emit_trade && entry_gone;
        opp_cmd.set_left  = emit_trade && !entry_gone;
        opp_cmd.data.left = rest_after;

        own_cmd            = '0;
        own_cmd.append     = do_append;
        own_cmd.data.id    = order_reg.order_id;
        own_cmd.data.price = order_reg.limit_price;
        own_cmd.data.left  = want_reg;

        bid_cmd = sell ? opp_cmd : own_cmd;
        ask_cmd = sell ? own_cmd : opp_cmd;
    end

    lobm_book #(
        .DEPTH (BOOK_DEPTH),
        .IW    (IW)
    ) u_bid (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (bid_cmd),
        .slot    (best_idx_reg),
        .rd_slot (rd_slot),
        .rd      (bid_rd),
        .valid   (bid_valid)
    );

    lobm_book #(
        .DEPTH (BOOK_DEPTH),
        .IW    (IW)
    ) u_ask (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ask_cmd),
        .slot    (best_idx_reg),
        .rd_slot (rd_slot),
        .rd      (ask_rd),
        .valid   (ask_valid)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            trade_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_trade)
            begin
                trade_reg <= trade_reg + 32'd1;
            end
            if (emit_trade || emit_final)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            order_reg    <= order;
            want_reg     <= order.quantity;
            scan_idx_reg <= '0;
        end
        if (state_reg == ST_SCAN)
        begin
            // Advance the scan; hold the best candidate so far
            if (better)
            begin
                best_idx_reg   <= scan_idx_reg;
                best_price_reg <= opp_rd.price;
            end
            scan_idx_reg <= scan_done ? '0 : scan_idx_reg + IW'(1);
        end
        if (emit_trade)
        begin
            want_reg                <= want_after;
            result_reg.kind         <= KIND_TRADE;
            result_reg.trade_number <= trade_reg;
            result_reg.buyer_id     <= sell ? opp_rd.id : order_reg.order_id;
            result_reg.seller_id    <= sell ? order_reg.order_id : opp_rd.id;
            result_reg.trade_price  <= opp_rd.price;
            result_reg.trade_qty    <= fill_qty;
            result_reg.left_qty     <= want_after;
            result_reg.last         <= 1'b0;
        end
        else if (emit_final)
        begin
            result_reg.kind         <= final_kind;
            result_reg.trade_number <= '0;
            result_reg.buyer_id     <= '0;
            result_reg.seller_id    <= '0;
            result_reg.trade_price  <= '0;
            result_reg.trade_qty    <= '0;
            result_reg.left_qty     <= want_reg;
            result_reg.last         <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LOBM_ASSERT_NOW(a_trade_not_last, result_valid && result.kind == KIND_TRADE, !result.last, "trade beat marked last")
    `LOBM_ASSERT_NOW(a_trade_qty_nonzero, result_valid && result.kind == KIND_TRADE, result.trade_qty != '0, "trade beat with zero quantity")
    `LOBM_ASSERT_NOW(a_bid_prefix, 1'b1, (bid_valid & (bid_valid + BOOK_DEPTH'(1))) == '0, "bid book not a prefix")
    `LOBM_ASSERT_NOW(a_ask_prefix, 1'b1, (ask_valid & (ask_valid + BOOK_DEPTH'(1))) == '0, "ask book not a prefix")
    `LOBM_ASSERT_NEXT(a_zero_qty_final, accept && order.quantity == '0, state_reg == ST_FINAL, "zero quantity order not finished at once")

endmodule

// ===== hw/rtl/lobm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_cell
// One book slot: shifts down from its upper neighbor, loads or updates.
// ----------------------------------------------------------------------------
module lobm_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  lobm_pkg::cell_ctl_t ctl,
    input  logic               nxt_valid,
    input  lobm_pkg::entry_t   nxt,
    input  lobm_pkg::entry_t   new_data,
    output logic               valid,
    output lobm_pkg::entry_t   entry
);
    import lobm_pkg::*;

    logic   valid_reg;
    entry_t entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.take_next)
        begin
            valid_reg <= nxt_valid;
        end
        else if (ctl.load_new)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_next)
        begin
            entry_reg <= nxt;
        end
        else if (ctl.load_new)
        begin
            entry_reg <= new_data;
        end
        else if (ctl.set_left)
        begin
            entry_reg.left <= new_data.left;
        end
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== hw/rtl/lobm_book.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_book
// One side of the book: a chain of cells kept in arrival order.
// ----------------------------------------------------------------------------
module lobm_book #(
    parameter int DEPTH = 16,
    parameter int IW    = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lobm_pkg::book_cmd_t cmd,
    input  logic [IW-1:0]       slot,
    input  logic [IW-1:0]       rd_slot,
    output lobm_pkg::entry_t    rd,
    output logic [DEPTH-1:0]    valid
);
    import lobm_pkg::*;

    entry_t entries [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctl_t ctl;
            logic      up_valid;
            entry_t    up_entry;
            logic      prev_valid;

            if (i == DEPTH - 1)
            begin : g_top
                assign up_valid = 1'b0;
                assign up_entry = '0;
            end
            else
            begin : g_mid
                assign up_valid = valid[i+1];
                assign up_entry = entries[i+1];
            end

            if (i == 0)
            begin : g_first
                assign prev_valid = 1'b1;
            end
            else
            begin : g_rest
                assign prev_valid = valid[i-1];
            end

            // Entries above the removed slot move down one place.
            assign ctl.take_next = cmd.remove && ((IW+1)'(i) >= {1'b0, slot});
            assign ctl.load_new  = cmd.append && !valid[i] && prev_valid;
            assign ctl.set_left  = cmd.set_left && ((IW+1)'(i) == {1'b0, slot});

            lobm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .nxt_valid (up_valid),
                .nxt       (up_entry),
                .new_data  (cmd.data),
                .valid     (valid[i]),
                .entry     (entries[i])
            );
        end
    endgenerate

    assign rd = entries[rd_slot];

endmodule
